FILE: sv/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg: shared types and constants for the interrupt controller
// Command codes, decoded operation kinds, error codes, init steps and the
// rotating priority search used by the execution side.
// ----------------------------------------------------------------------------
package pic_pkg;

	// Input command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_RAISE = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	// Result error codes
	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_ICW1_SEQ = 2'd1;
	localparam logic [1:0] ERR_CMD_READ = 2'd2;

	// Initialization sequence position
	localparam logic [1:0] STEP_ICW1 = 2'd0;
	localparam logic [1:0] STEP_ICW2 = 2'd1;
	localparam logic [1:0] STEP_ICW3 = 2'd2;
	localparam logic [1:0] STEP_ICW4 = 2'd3;

	// Command byte bit positions
	localparam int BIT_ICW1   = 4;
	localparam int BIT_OCW3   = 3;
	localparam int BIT_EOI    = 5;
	localparam int BIT_SL     = 6;
	localparam int BIT_R      = 7;
	localparam int BIT_IC4    = 0;
	localparam int BIT_AEOI   = 1;
	localparam int BIT_RR     = 1;
	localparam int BIT_RIS    = 0;

	localparam logic [7:0] MASK_RESET   = 8'hff;
	localparam logic [7:0] BASE_KEEP    = 8'hfc;
	localparam logic [2:0] LOWEST_RESET = 3'd7;

	// Queue between decode and execute
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Decoded operation kinds
	typedef enum logic [2:0] {
		OP_ICW1,
		OP_OCW2,
		OP_OCW3,
		OP_DATA_WR,
		OP_DATA_RD,
		OP_CMD_RD,
		OP_RAISE,
		OP_TICK
	} op_kind_t;

	// One decoded beat
	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data;
		logic [2:0] line;
	} op_t;

	// Result of a priority search
	typedef struct packed {
		logic       found;
		logic [2:0] level;
	} pick_t;

	// Highest-priority set bit, searching upward from lowest + 1 with wrap
	function automatic pick_t pick_level(input logic [7:0] bits, input logic [2:0] lowest);
		pick_t      p;
		logic [2:0] lv;
		p.found = 1'b0;
		p.level = 3'd0;
		// walk from weakest to strongest so the strongest hit wins
		for (int i = 7; i >= 0; i--) begin
			lv = lowest + 3'(i + 1);
			if (bits[lv]) begin
				p.found = 1'b1;
				p.level = lv;
			end
		end
		return p;
	endfunction

endpackage

FILE: sv/pic_front.sv
// ----------------------------------------------------------------------------
// pic_front: input decode
// Classifies each accepted beat into an operation kind and pushes it into
// the queue. Stalls the input while the queue is full.
// ----------------------------------------------------------------------------
module pic_front import pic_pkg::*; (
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic       port_is_data,
	input  logic [7:0] write_data,
	input  logic [2:0] irq_line,
	input  logic       q_full,
	output logic       q_push,
	output op_t        q_op
);

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// command classification
	always_comb begin
		q_op.data = write_data;
		q_op.line = irq_line;
		case (command)
			CMD_WRITE: begin
				if (port_is_data)
					q_op.kind = OP_DATA_WR;
				else if (write_data[BIT_ICW1])
					q_op.kind = OP_ICW1;
				else if (write_data[BIT_OCW3])
					q_op.kind = OP_OCW3;
				else
					q_op.kind = OP_OCW2;
			end
			CMD_READ: begin
				q_op.kind = port_is_data ? OP_DATA_RD : OP_CMD_RD;
			end
			CMD_RAISE: begin
				q_op.kind = OP_RAISE;
			end
			default: begin
				q_op.kind = OP_TICK;
			end
		endcase
	end

endmodule

FILE: sv/pic_queue.sv
// ----------------------------------------------------------------------------
// pic_queue: decoded-beat queue
// Short FIFO between decode and execute so each side stalls on its own.
// Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module pic_queue import pic_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output op_t  head_op
);

	op_t               entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head_op   = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_op;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
`endif

endmodule

FILE: sv/pic_back.sv
// ----------------------------------------------------------------------------
// pic_back: execution and result register
// Holds the controller state, carries out one decoded beat per cycle
// unless the output register is stalled, and drives the output register.
// ----------------------------------------------------------------------------
module pic_back import pic_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_not_empty,
	input  op_t        q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       read_valid,
	output logic [7:0] vector,
	output logic       vector_valid,
	output logic [1:0] error_code
);

	// controller state
	logic [1:0] init_step_q;
	logic       need_icw4_q;
	logic       auto_eoi_q;
	logic [7:0] vector_base_q;
	logic [7:0] mask_q;
	logic [7:0] request_q;
	logic [7:0] service_q;
	logic [2:0] lowest_q;
	logic       rotate_aeoi_q;
	logic [1:0] read_select_q;

	// next state
	logic [1:0] init_step_d;
	logic       need_icw4_d;
	logic       auto_eoi_d;
	logic [7:0] vector_base_d;
	logic [7:0] mask_d;
	logic [7:0] request_d;
	logic [7:0] service_d;
	logic [2:0] lowest_d;
	logic       rotate_aeoi_d;
	logic [1:0] read_select_d;

	// result of this beat
	logic [7:0] rd_d;
	logic       rv_d;
	logic [7:0] vec_d;
	logic       vv_d;
	logic [1:0] err_d;

	// output register
	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       read_valid_q;
	logic [7:0] vector_q;
	logic       vector_valid_q;
	logic [1:0] error_code_q;

	logic [7:0] line_bit;
	logic [7:0] level_bit;
	pick_t      isr_pick;
	pick_t      irr_pick;
	logic [7:0] isr_pick_bit;
	logic [7:0] irr_pick_bit;

	assign q_pop = q_not_empty && (!out_valid_q || !out_stall);

	assign line_bit     = 8'b1 << q_head.line;
	assign level_bit    = 8'b1 << q_head.data[2:0];
	assign isr_pick     = pick_level(service_q, lowest_q);
	assign irr_pick     = pick_level(request_q & ~mask_q, lowest_q);
	assign isr_pick_bit = 8'b1 << isr_pick.level;
	assign irr_pick_bit = 8'b1 << irr_pick.level;

	// execute one beat
	always_comb begin
		init_step_d   = init_step_q;
		need_icw4_d   = need_icw4_q;
		auto_eoi_d    = auto_eoi_q;
		vector_base_d = vector_base_q;
		mask_d        = mask_q;
		request_d     = request_q;
		service_d     = service_q;
		lowest_d      = lowest_q;
		rotate_aeoi_d = rotate_aeoi_q;
		read_select_d = read_select_q;
		rd_d  = 8'd0;
		rv_d  = 1'b0;
		vec_d = 8'd0;
		vv_d  = 1'b0;
		err_d = ERR_OK;
		case (q_head.kind)
			OP_ICW1: begin
				if (init_step_q != STEP_ICW1) begin
					err_d = ERR_ICW1_SEQ;
				end else begin
					need_icw4_d = q_head.data[BIT_IC4];
					init_step_d = STEP_ICW2;
				end
			end
			OP_OCW3: begin
				read_select_d = q_head.data[1:0];
			end
			OP_OCW2: begin
				// R / SL / EOI actions
				if (q_head.data[BIT_EOI]) begin
					if (q_head.data[BIT_SL]) begin
						service_d = service_q & ~level_bit;
						if (q_head.data[BIT_R])
							lowest_d = q_head.data[2:0];
					end else if (isr_pick.found) begin
						service_d = service_q & ~isr_pick_bit;
						if (q_head.data[BIT_R])
							lowest_d = isr_pick.level;
					end
				end else if (q_head.data[BIT_SL]) begin
					if (q_head.data[BIT_R])
						lowest_d = q_head.data[2:0];
				end else begin
					rotate_aeoi_d = q_head.data[BIT_R];
				end
			end
			OP_DATA_WR: begin
				case (init_step_q)
					STEP_ICW2: begin
						vector_base_d = q_head.data & BASE_KEEP;
						init_step_d   = need_icw4_q ? STEP_ICW3 : STEP_ICW1;
					end
					STEP_ICW3: begin
						init_step_d = STEP_ICW4;
					end
					STEP_ICW4: begin
						auto_eoi_d  = q_head.data[BIT_AEOI];
						init_step_d = STEP_ICW1;
					end
					default: begin
						mask_d = q_head.data;
					end
				endcase
			end
			OP_DATA_RD: begin
				rv_d = 1'b1;
				if (!read_select_q[BIT_RR])
					rd_d = mask_q;
				else if (read_select_q[BIT_RIS])
					rd_d = service_q;
				else
					rd_d = request_q;
			end
			OP_CMD_RD: begin
				err_d = ERR_CMD_READ;
			end
			OP_RAISE: begin
				if (((request_q | service_q | mask_q) & line_bit) == 8'd0)
					request_d = request_q | line_bit;
			end
			default: begin
				// tick: deliver the strongest pending unmasked request
				if (irr_pick.found) begin
					request_d = request_q & ~irr_pick_bit;
					vec_d     = vector_base_q + {5'd0, irr_pick.level};
					vv_d      = 1'b1;
					if (!auto_eoi_q)
						service_d = service_q | irr_pick_bit;
					else if (rotate_aeoi_q)
						lowest_d = irr_pick.level;
				end
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_step_q   <= STEP_ICW1;
			need_icw4_q   <= 1'b0;
			auto_eoi_q    <= 1'b0;
			vector_base_q <= 8'd0;
			mask_q        <= MASK_RESET;
			request_q     <= 8'd0;
			service_q     <= 8'd0;
			lowest_q      <= LOWEST_RESET;
			rotate_aeoi_q <= 1'b0;
			read_select_q <= 2'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				init_step_q   <= init_step_d;
				need_icw4_q   <= need_icw4_d;
				auto_eoi_q    <= auto_eoi_d;
				vector_base_q <= vector_base_d;
				mask_q        <= mask_d;
				request_q     <= request_d;
				service_q     <= service_d;
				lowest_q      <= lowest_d;
				rotate_aeoi_q <= rotate_aeoi_d;
				read_select_q <= read_select_d;
				out_valid_q   <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			read_data_q    <= rd_d;
			read_valid_q   <= rv_d;
			vector_q       <= vec_d;
			vector_valid_q <= vv_d;
			error_code_q   <= err_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = read_data_q;
	assign read_valid   = read_valid_q;
	assign vector       = vector_q;
	assign vector_valid = vector_valid_q;
	assign error_code   = error_code_q;

`ifndef ASSERT_OFF
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && read_valid_q |-> !vector_valid_q)
		else $error("read and vector in one beat");
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && error_code_q != ERR_OK |-> !read_valid_q && !vector_valid_q)
		else $error("error beat carries data");
	a_irr_isr_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(request_q & service_q) == 8'd0)
		else $error("level both requested and in service");
`endif

endmodule

FILE: sv/programmable_interrupt_controller_top.sv
// ----------------------------------------------------------------------------
// programmable_interrupt_controller_top: 8-line interrupt controller
// Decode front end, a short beat queue, and an execution back end that
// holds the init sequence, mask, request, in-service and rotation state.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | command, port_is_data, write_data, irq_line
//  out     | out_valid / out_stall| read_data, read_valid, vector,
//          |                      | vector_valid, error_code
//
//  Throughput is one beat per cycle while out_stall is low; the back end then
//  executes one queued beat per cycle, and its 8-level rotating priority
//  search is combinational. A beat is registered in the queue and then in
//  the output register. The 2-entry queue absorbs output stalls; in_stall
//  rises when full. Reset is asynchronous; beats are taken once it is released.
//
module programmable_interrupt_controller_top import pic_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic       port_is_data,
	input  logic [7:0] write_data,
	input  logic [2:0] irq_line,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       read_valid,
	output logic [7:0] vector,
	output logic       vector_valid,
	output logic [1:0] error_code
);

	logic q_full;
	logic q_push;
	op_t  q_push_op;
	logic q_pop;
	logic q_not_empty;
	op_t  q_head;

	// decode
	pic_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.port_is_data (port_is_data),
		.write_data   (write_data),
		.irq_line     (irq_line),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_op         (q_push_op)
	);

	// beat queue
	pic_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (q_push_op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_op   (q_head)
	);

	// execute
	pic_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.read_valid   (read_valid),
		.vector       (vector),
		.vector_valid (vector_valid),
		.error_code   (error_code)
	);

endmodule

FILE: dv/programmable_interrupt_controller_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// programmable_interrupt_controller_top_tb: self-checking bench for the PIC
// Drives port writes, port reads, line raises and ticks through the input
// channel. A scoreboard mirrors the controller state, predicts one response
// per accepted beat and compares every field of every response beat. Both
// channels idle at random, with a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module programmable_interrupt_controller_top_tb;
	import pic_pkg::*;

	localparam int RANDOM_BEATS    = 850;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int MAX_PRINTED     = 50;
	localparam logic [7:0] ICW1_FLAG = 8'h01 << BIT_ICW1;
	localparam logic [7:0] OCW3_FLAG = 8'h01 << BIT_OCW3;

	// One input beat and one response beat
	typedef struct packed {
		logic [1:0] command;
		logic       is_data;
		logic [7:0] data;
		logic [2:0] line;
	} pic_beat_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       read_valid;
		logic [7:0] vector;
		logic       vector_valid;
		logic [1:0] error_code;
	} pic_response_t;

	// Mirrors the controller state and holds the responses still owed
	class irq_ctrl_scoreboard;
		logic [1:0]    init_step;
		logic          need_icw4;
		logic          auto_eoi;
		logic          rotate_on_aeoi;
		logic [7:0]    vector_base;
		logic [7:0]    mask_reg;
		logic [7:0]    request_reg;
		logic [7:0]    service_reg;
		logic [2:0]    lowest_level;
		logic [1:0]    read_select;
		pic_response_t expected_responses[$];
		int            mismatch_count;

		function new();
			init_step      = STEP_ICW1;
			need_icw4      = 1'b0;
			auto_eoi       = 1'b0;
			rotate_on_aeoi = 1'b0;
			vector_base    = 8'h00;
			mask_reg       = MASK_RESET;
			request_reg    = 8'h00;
			service_reg    = 8'h00;
			lowest_level   = LOWEST_RESET;
			read_select    = 2'b00;
			mismatch_count = 0;
		endfunction

		// Strongest set level, starting just above the lowest-priority level
		function logic find_top(input logic [7:0] bits, output logic [2:0] level);
			logic [2:0] cand;
			level = 3'd0;
			for (int i = 1; i <= 8; i++) begin
				cand = lowest_level + 3'(i);
				if (bits[cand]) begin
					level = cand;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		// Update the mirrored state for one accepted beat, queue its response
		function void note_beat(input pic_beat_t b);
			pic_response_t r;
			logic [2:0]    lv;
			r = '0;
			case (b.command)
				CMD_WRITE: begin
					if (!b.is_data) begin
						if (b.data[BIT_ICW1]) begin
							if (init_step != STEP_ICW1) begin
								r.error_code = ERR_ICW1_SEQ;
							end else begin
								need_icw4 = b.data[BIT_IC4];
								init_step = STEP_ICW2;
							end
						end else if (b.data[BIT_OCW3]) begin
							read_select = {b.data[BIT_RR], b.data[BIT_RIS]};
						end else begin
							// OCW2: EOI, rotation and priority set
							lv = b.data[2:0];
							if (b.data[BIT_EOI]) begin
								if (b.data[BIT_SL]) begin
									service_reg[lv] = 1'b0;
									if (b.data[BIT_R])
										lowest_level = lv;
								end else if (find_top(service_reg, lv)) begin
									service_reg[lv] = 1'b0;
									if (b.data[BIT_R])
										lowest_level = lv;
								end
							end else if (b.data[BIT_SL]) begin
								if (b.data[BIT_R])
									lowest_level = lv;
							end else begin
								rotate_on_aeoi = b.data[BIT_R];
							end
						end
					end else begin
						case (init_step)
							STEP_ICW2: begin
								vector_base = b.data & BASE_KEEP;
								init_step   = need_icw4 ? STEP_ICW3 : STEP_ICW1;
							end
							STEP_ICW3: init_step = STEP_ICW4;
							STEP_ICW4: begin
								auto_eoi  = b.data[BIT_AEOI];
								init_step = STEP_ICW1;
							end
							default: mask_reg = b.data;
						endcase
					end
				end
				CMD_READ: begin
					if (!b.is_data) begin
						r.error_code = ERR_CMD_READ;
					end else begin
						r.read_valid = 1'b1;
						if (!read_select[BIT_RR])
							r.read_data = mask_reg;
						else if (read_select[BIT_RIS])
							r.read_data = service_reg;
						else
							r.read_data = request_reg;
					end
				end
				CMD_RAISE: begin
					// busy or masked lines are dropped
					if (!request_reg[b.line] && !service_reg[b.line] && !mask_reg[b.line])
						request_reg[b.line] = 1'b1;
				end
				CMD_TICK: begin
					if (find_top(request_reg & ~mask_reg, lv)) begin
						request_reg[lv] = 1'b0;
						r.vector        = vector_base + 8'(lv);
						r.vector_valid  = 1'b1;
						if (!auto_eoi)
							service_reg[lv] = 1'b1;
						else if (rotate_on_aeoi)
							lowest_level = lv;
					end
				end
				default: ;
			endcase
			expected_responses.push_back(r);
		endfunction

		task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
			mismatch_count++;
			if (mismatch_count <= MAX_PRINTED)
				$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
		endtask

		// Compare one response beat against the oldest prediction
		task check_result(input pic_response_t got);
			pic_response_t want;
			if (expected_responses.size() == 0) begin
				report_mismatch("response with none pending", 8'h00, 8'h00);
				return;
			end
			want = expected_responses.pop_front();
			if (got.read_data !== want.read_data)
				report_mismatch("read_data", got.read_data, want.read_data);
			if (got.read_valid !== want.read_valid)
				report_mismatch("read_valid", 8'(got.read_valid), 8'(want.read_valid));
			if (got.vector !== want.vector)
				report_mismatch("vector", got.vector, want.vector);
			if (got.vector_valid !== want.vector_valid)
				report_mismatch("vector_valid", 8'(got.vector_valid), 8'(want.vector_valid));
			if (got.error_code !== want.error_code)
				report_mismatch("error_code", 8'(got.error_code), 8'(want.error_code));
		endtask
	endclass

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic [1:0] command      = CMD_WRITE;
	logic       port_is_data = 1'b0;
	logic [7:0] write_data   = 8'h00;
	logic [2:0] irq_line     = 3'd0;
	logic       out_stall    = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] read_data;
	logic       read_valid;
	logic [7:0] vector;
	logic       vector_valid;
	logic [1:0] error_code;

	int   idle_percent  = 20;
	logic hold_off_req  = 1'b0;
	int   hold_off_left = 0;
	int   beats_sent    = 0;
	int   cycle_count   = 0;

	irq_ctrl_scoreboard scoreboard = new();

	programmable_interrupt_controller_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.port_is_data(port_is_data),
		.write_data  (write_data),
		.irq_line    (irq_line),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.read_valid  (read_valid),
		.vector      (vector),
		.vector_valid(vector_valid),
		.error_code  (error_code)
	);

	always #1 clk = ~clk;

	// Sample both channels at the rising edge
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			scoreboard.note_beat(pic_beat_t'({command, port_is_data, write_data, irq_line}));
		if (out_valid && !out_stall)
			scoreboard.check_result(pic_response_t'({read_data, read_valid, vector,
				vector_valid, error_code}));
	end

	// Response side: random stalls, plus a long hold-off on request
	initial begin : receiver
		forever begin
			@(negedge clk);
			if (hold_off_left != 0) begin
				out_stall <= 1'b1;
				hold_off_left--;
			end else if (hold_off_req) begin
				hold_off_req  = 1'b0;
				hold_off_left = HOLD_OFF_CYCLES - 1;
				out_stall    <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < idle_percent);
			end
		end
	end

	// Run-away guard
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Offer one beat, with optional idle cycles first, and hold it until taken
	task automatic send_beat(input logic [1:0] cmd, input logic is_data,
			input logic [7:0] data, input logic [2:0] line);
		while ($urandom_range(0, 99) < idle_percent) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		command      <= cmd;
		port_is_data <= is_data;
		write_data   <= data;
		irq_line     <= line;
		do @(posedge clk); while (in_stall);
		beats_sent++;
	endtask

	task automatic write_cmd(input logic [7:0] data);
		send_beat(CMD_WRITE, 1'b0, data, 3'($urandom));
	endtask

	task automatic write_data_port(input logic [7:0] data);
		send_beat(CMD_WRITE, 1'b1, data, 3'($urandom));
	endtask

	task automatic read_port(input logic is_data);
		send_beat(CMD_READ, is_data, 8'($urandom), 3'($urandom));
	endtask

	task automatic raise_line(input logic [2:0] line);
		send_beat(CMD_RAISE, 1'($urandom), 8'($urandom), line);
	endtask

	task automatic clock_tick();
		send_beat(CMD_TICK, 1'($urandom), 8'($urandom), 3'($urandom));
	endtask

	initial begin : stimulus
		int         session;
		int         first_random;
		int         pick;
		logic [7:0] icw1;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset values, init with and without ICW4, EOI and rotation
		read_port(1'b1);             // mask reads back all set
		read_port(1'b0);             // command port read is an error
		clock_tick();                // nothing pending
		raise_line(3'd3);            // masked, dropped
		write_cmd(ICW1_FLAG);        // ICW1 without ICW4
		write_cmd(8'h1f);            // ICW1 out of sequence
		write_data_port(8'h03);      // base, low bits dropped
		write_data_port(8'h00);      // unmask all
		raise_line(3'd7);
		raise_line(3'd0);
		raise_line(3'd7);            // already requested
		clock_tick();                // level 0 first after reset
		raise_line(3'd0);            // in service, dropped
		write_cmd(8'h0b);            // select ISR read
		read_port(1'b1);
		write_cmd(8'ha0);            // rotate on non-specific EOI
		clock_tick();
		write_cmd(8'he7);            // rotate on specific EOI, level 7
		write_cmd(8'hc4);            // set lowest priority to 4
		write_cmd(8'hff);            // ICW1 with ICW4
		write_data_port(8'hff);      // base 0xfc
		write_data_port(8'haa);      // ICW3 ignored
		write_data_port(8'hff);      // auto EOI on
		write_cmd(8'h80);            // rotate in auto EOI
		raise_line(3'd5);
		clock_tick();                // vector wraps past 0xff
		write_cmd(8'h20);            // non-specific EOI with nothing in service
		write_cmd(8'h0a);            // select IRR read
		read_port(1'b1);

		// Random sessions: init sequence, mask, then a burst of operations
		first_random = beats_sent;
		session      = 0;
		while (beats_sent - first_random < RANDOM_BEATS) begin
			case (session % 12)
				3: idle_percent = 0;
				6: idle_percent = 20;
				8: hold_off_req = 1'b1;
				10: begin
					// stop offering, then wait until every response is back
					@(negedge clk);
					in_valid <= 1'b0;
					while (scoreboard.expected_responses.size() != 0) @(posedge clk);
				end
				default: ;
			endcase

			if ($urandom_range(0, 9) != 0) begin
				icw1 = 8'($urandom) | ICW1_FLAG;
				write_cmd(icw1);
				// occasionally break the sequence with a stray ICW1
				if ($urandom_range(0, 7) == 0)
					write_cmd(8'($urandom) | ICW1_FLAG);
				write_data_port(8'($urandom));
				if (icw1[BIT_IC4]) begin
					write_data_port(8'($urandom));
					write_data_port(8'($urandom));
				end
				write_data_port($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
			end

			repeat ($urandom_range(15, 40)) begin
				pick = $urandom_range(0, 99);
				if (pick < 30)
					raise_line(3'($urandom));
				else if (pick < 55)
					clock_tick();
				else if (pick < 68)
					write_cmd({3'($urandom), 2'b00, 3'($urandom)});
				else if (pick < 76)
					write_cmd((8'($urandom) & ~(ICW1_FLAG | 8'h0)) | OCW3_FLAG);
				else if (pick < 88)
					read_port(1'b1);
				else if (pick < 92)
					write_data_port(8'($urandom));
				else if (pick < 96)
					read_port(1'b0);
				else
					send_beat(2'($urandom), 1'($urandom), 8'($urandom), 3'($urandom));
			end
			session++;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (scoreboard.expected_responses.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (scoreboard.mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
